>>> src/aom_pkg.sv
// Shared types and constants for the autoranging ohmmeter.
`timescale 1ns / 1ps
package aom_pkg;

    localparam logic [1:0] REF_NONE = 2'd0;
    localparam logic [1:0] REF_LOW  = 2'd1;
    localparam logic [1:0] REF_MID  = 2'd2;
    localparam logic [1:0] REF_HIGH = 2'd3;

    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_FIRST  = 2'd1;
    localparam logic [1:0] PHASE_SECOND = 2'd2;

    localparam logic [2:0] CFG_ADC_FULL   = 3'd0;
    localparam logic [2:0] CFG_REF_LOW    = 3'd1;
    localparam logic [2:0] CFG_REF_MID    = 3'd2;
    localparam logic [2:0] CFG_REF_HIGH   = 3'd3;
    localparam logic [2:0] CFG_CONT_LIMIT = 3'd4;

    localparam logic [11:0] RST_ADC_FULL   = 12'd3300;
    localparam logic [15:0] RST_REF_LOW    = 16'd100;
    localparam logic [15:0] RST_REF_MID    = 16'd1000;
    localparam logic [15:0] RST_REF_HIGH   = 16'd10000;
    localparam logic [15:0] RST_CONT_LIMIT = 16'd50;

    localparam int OPEN_MV      = 3200;
    localparam int SHORT_MV     = 50;
    localparam int LOW_LIMIT    = 500;
    localparam int MID_LIMIT    = 5000;
    localparam int OVER_LIMIT   = 500000;

    typedef struct packed {
        logic        mode;
        logic [11:0] sample_mv;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [1:0]  ref_select;
        logic [31:0] ohms_x16;
        logic [1:0]  range_used;
        logic        continuity;
        logic        open_circuit;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  addr;
        logic [15:0] wdata;
    } t_cfg_item;

endpackage

>>> src/aom_chan_if.sv
// Valid/ready channel carrying one item of a given type.
`timescale 1ns / 1ps
interface aom_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/aom_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module aom_divider #(
    parameter int DW = 40,
    parameter int RW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [RW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quo,
    output logic [RW-1:0] o_rem
);
    localparam int KW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic [KW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_quo, n_quo;
    logic [RW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_div, n_div;
    logic [RW:0]   trial;
    logic          ge;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        ge    = trial >= {1'b0, r_div};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = KW'(DW);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem  = ge ? RW'(trial - {1'b0, r_div}) : trial[RW-1:0];
            n_quo  = {r_quo[DW-2:0], ge};
            n_cnt  = r_cnt - KW'(1);
            n_busy = r_cnt != KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

>>> src/autorange_ohmmeter.sv
// Top level of the autoranging voltage-divider ohmmeter.
//
// Channels: i_samp takes items of {mode, sample_mv}; mode 1 starts a
// measurement, mode 0 carries one junction sample. o_res gives request
// items (kind 0, reference to drive) and finished items (kind 1: ohms x16,
// range, continuity and open flags). i_cfg writes the five registers and
// is always ready.
// Timing: a start item gives its high-reference request on the next
// cycle. After the last sample of a pass the block runs S_MUL, then S_DIV,
// where the bit-serial divider, DW bits wide (DW = 32 + OHMS_FRACTION_BITS
// at default sizes), gives one quotient bit a cycle, then S_EVAL. Samples are
// taken one a cycle within a pass unless an item waits on a stalled output;
// i_samp.ready is low from the last sample of a pass until its result is loaded.
// A stalled receiver holds the result in the output register; a new item is
// taken in the cycle the waiting one leaves.
// Reset: registers return to 3300 mV, 100, 1000, 10000 and 50 ohm, and the
// block waits idle for a start item; samples while idle are dropped.
`timescale 1ns / 1ps
module autorange_ohmmeter #(
    parameter int SAMPLES_PER_READING = 16,
    parameter int OHMS_FRACTION_BITS  = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aom_chan_if.sink      i_samp,
    aom_chan_if.source    o_res,
    aom_chan_if.sink      i_cfg
);
    import aom_pkg::*;

    localparam int N    = SAMPLES_PER_READING;
    localparam int F    = OHMS_FRACTION_BITS;
    localparam int SW   = $clog2(N * 4095 + 1);
    localparam int CW   = $clog2(N + 1);
    localparam int NUMW = 16 + SW;
    localparam int DW   = NUMW + F;
    localparam int QX   = (DW > 32) ? DW : 33;

    localparam logic [SW-1:0] OPEN_SUM  = SW'(OPEN_MV * N);
    localparam logic [SW-1:0] SHORT_SUM = SW'(SHORT_MV * N);
    localparam logic [DW-1:0] Q_LOW     = DW'(longint'(LOW_LIMIT) << F);
    localparam logic [DW-1:0] Q_MID     = DW'(longint'(MID_LIMIT) << F);
    localparam logic [DW-1:0] Q_OVER    = DW'(longint'(OVER_LIMIT) << F);

    localparam logic [1:0] S_ACC  = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EVAL = 2'd3;

    logic [11:0]   r_adc;
    logic [15:0]   r_ref_low, r_ref_mid, r_ref_high, r_limit;
    logic [1:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [1:0]    r_ref, n_ref;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_sum, n_sum;
    logic          r_open, n_open;
    logic          r_ov, n_ov;
    t_out_item     r_out, n_out;

    logic          out_free, in_acc;
    logic [SW-1:0] full;
    logic [15:0]   rref;
    logic          is_open, is_short;
    logic [NUMW-1:0] num;
    logic [SW-1:0] den;
    logic          div_busy;
    logic [DW-1:0] quo;
    logic [SW-1:0] rem;
    logic [QX-1:0] quo_x;
    logic          below_low, below_mid, cont, over;
    logic [31:0]   scaled;

    assign out_free     = !r_ov || o_res.ready;
    assign i_samp.ready = (r_state == S_ACC) && out_free;
    assign in_acc       = i_samp.valid && i_samp.ready;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc      <= RST_ADC_FULL;
            r_ref_low  <= RST_REF_LOW;
            r_ref_mid  <= RST_REF_MID;
            r_ref_high <= RST_REF_HIGH;
            r_limit    <= RST_CONT_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.addr)
                CFG_ADC_FULL:   r_adc      <= i_cfg.data.wdata[11:0];
                CFG_REF_LOW:    r_ref_low  <= i_cfg.data.wdata;
                CFG_REF_MID:    r_ref_mid  <= i_cfg.data.wdata;
                CFG_REF_HIGH:   r_ref_high <= i_cfg.data.wdata;
                CFG_CONT_LIMIT: r_limit    <= i_cfg.data.wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        full     = SW'(r_adc * N);
        rref     = (r_ref == REF_LOW) ? r_ref_low
                 : (r_ref == REF_MID) ? r_ref_mid : r_ref_high;
        is_open  = (r_sum >= OPEN_SUM) || (full <= r_sum);
        is_short = r_sum <= SHORT_SUM;
        if (is_open || is_short) begin
            num = '0;
            den = SW'(1);
        end else begin
            num = NUMW'(rref) * NUMW'(r_sum);
            den = full - r_sum;
        end
    end

    aom_divider #(
        .DW (DW),
        .RW (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_MUL),
        .i_dividend (DW'(num) << F),
        .i_divisor  (den),
        .o_busy     (div_busy),
        .o_quo      (quo),
        .o_rem      (rem)
    );

    always_comb begin
        quo_x     = QX'(quo);
        below_low = !r_open && (quo < Q_LOW);
        below_mid = !r_open && (quo < Q_MID);
        cont      = !r_open && (quo < (DW'(r_limit) << F));
        over      = r_open || (quo > Q_OVER) || ((quo == Q_OVER) && (rem != '0));
        scaled    = (r_open || (quo_x[QX-1:32] != '0)) ? '1 : quo_x[31:0];
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_ref   = r_ref;
        n_count = r_count;
        n_sum   = r_sum;
        n_open  = r_open;
        n_ov    = r_ov && !o_res.ready;
        n_out   = r_out;
        unique case (r_state)
            S_ACC: begin
                if (in_acc) begin
                    if (i_samp.data.mode) begin
                        n_phase = PHASE_FIRST;
                        n_ref   = REF_HIGH;
                        n_count = '0;
                        n_sum   = '0;
                        n_ov    = 1'b1;
                        n_out   = '{kind: 1'b0, ref_select: REF_HIGH, default: '0};
                    end else if (r_phase != PHASE_IDLE) begin
                        n_sum   = r_sum + SW'(i_samp.data.sample_mv);
                        n_count = r_count + CW'(1);
                        if (r_count == CW'(N - 1)) begin
                            n_state = S_MUL;
                        end
                    end
                end
            end
            S_MUL: begin
                n_open  = is_open;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!div_busy) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    n_state = S_ACC;
                    n_ov    = 1'b1;
                    n_count = '0;
                    n_sum   = '0;
                    if (r_phase == PHASE_FIRST && (below_low || below_mid)) begin
                        n_phase = PHASE_SECOND;
                        n_ref   = below_low ? REF_LOW : REF_MID;
                        n_out   = '{kind: 1'b0, ref_select: n_ref, default: '0};
                    end else begin
                        n_phase = PHASE_IDLE;
                        n_ref   = REF_NONE;
                        n_out   = '{kind: 1'b1, ref_select: REF_NONE, ohms_x16: scaled,
                                    range_used: r_ref - 2'd1, continuity: cont,
                                    open_circuit: over};
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_phase <= PHASE_IDLE;
            r_ref   <= REF_NONE;
            r_count <= '0;
            r_sum   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_ref   <= n_ref;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_ov    <= n_ov;
        end
        r_open <= n_open;
        r_out  <= n_out;
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;
endmodule

>>> src/aom_checker.sv
// Port-level checks for the autoranging ohmmeter, bound to the top level.
`timescale 1ns / 1ps
module aom_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input aom_pkg::t_in_item  i_in_item,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input aom_pkg::t_out_item i_out_item
);
    import aom_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result item changed while stalled");

    a_start_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_item.mode |=>
            i_out_valid && !i_out_item.kind && (i_out_item.ref_select == REF_HIGH))
        else $error("start item gave no high-reference request");

    a_req_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.kind |->
            (i_out_item.ohms_x16 == '0) && (i_out_item.range_used == 2'd0)
            && !i_out_item.continuity && !i_out_item.open_circuit
            && (i_out_item.ref_select != REF_NONE))
        else $error("malformed request item");

    a_final_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.kind |->
            (i_out_item.ref_select == REF_NONE) && (i_out_item.range_used != 2'd3)
            && !(i_out_item.continuity && i_out_item.open_circuit))
        else $error("malformed finished item");
endmodule

bind autorange_ohmmeter aom_checker u_aom_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_samp.valid),
    .i_in_ready  (i_samp.ready),
    .i_in_item   (i_samp.data),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_item  (o_res.data)
);

>>> sim/aom_reading_check.sv
`timescale 1ns / 1ps
// Watches the ohmmeter channels, predicts each reading and compares it with the block.
module aom_reading_check
    import aom_pkg::*;
#(
    parameter int SAMPLES   = 16,
    parameter int FRAC_BITS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_samp_valid,
    input  logic      i_samp_ready,
    input  t_in_item  i_samp_data,
    input  logic      i_res_valid,
    input  logic      i_res_ready,
    input  t_out_item i_res_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  t_cfg_item i_cfg_data,
    output int        o_errors,
    output int        o_pending
);

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_READING = 1'b1;

    logic [11:0] full_mv;
    logic [15:0] ref_low_r;
    logic [15:0] ref_mid_r;
    logic [15:0] ref_high_r;
    logic [15:0] cont_limit;

    logic [1:0]  meter_phase;
    logic [1:0]  drive_ref;
    int unsigned samples_taken;
    logic [19:0] mv_sum;

    t_out_item   expected_readings[$];

    function automatic void start_pass(input logic [1:0] sel, input logic [1:0] ph);
        meter_phase   = ph;
        drive_ref     = sel;
        samples_taken = 0;
        mv_sum        = '0;
    endfunction

    function automatic void push_request(input logic [1:0] sel);
        t_out_item r;
        r            = '0;
        r.kind       = KIND_REQUEST;
        r.ref_select = sel;
        expected_readings.push_back(r);
    endfunction

    function automatic void write_reg(input t_cfg_item w);
        case (w.addr)
            CFG_ADC_FULL:   full_mv    = w.wdata[11:0];
            CFG_REF_LOW:    ref_low_r  = w.wdata;
            CFG_REF_MID:    ref_mid_r  = w.wdata;
            CFG_REF_HIGH:   ref_high_r = w.wdata;
            CFG_CONT_LIMIT: cont_limit = w.wdata;
            default: ;
        endcase
    endfunction

    function automatic void predict_reading(input t_in_item it);
        logic [63:0] s;
        logic [63:0] full;
        logic [63:0] rref;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] scaled;
        logic        is_open;
        logic        below_low;
        logic        below_mid;
        t_out_item   r;
        if (it.mode) begin
            start_pass(REF_HIGH, PHASE_FIRST);
            push_request(REF_HIGH);
            return;
        end
        if (meter_phase == PHASE_IDLE)
            return;
        mv_sum = mv_sum + 20'(it.sample_mv);
        samples_taken++;
        if (samples_taken < SAMPLES)
            return;

        s    = 64'(mv_sum);
        full = 64'(SAMPLES) * 64'(full_mv);
        rref = (drive_ref == REF_LOW) ? 64'(ref_low_r)
             : (drive_ref == REF_MID) ? 64'(ref_mid_r) : 64'(ref_high_r);
        is_open = (s >= 64'(OPEN_MV) * 64'(SAMPLES)) || (full <= s);
        if (is_open || s <= 64'(SHORT_MV) * 64'(SAMPLES)) begin
            num = 64'd0;
            den = 64'd1;
        end else begin
            num = rref * s;
            den = full - s;
        end
        below_low = !is_open && (num < 64'(LOW_LIMIT) * den);
        below_mid = !is_open && (num < 64'(MID_LIMIT) * den);

        if (meter_phase == PHASE_FIRST && below_low) begin
            start_pass(REF_LOW, PHASE_SECOND);
            push_request(REF_LOW);
            return;
        end
        if (meter_phase == PHASE_FIRST && below_mid) begin
            start_pass(REF_MID, PHASE_SECOND);
            push_request(REF_MID);
            return;
        end

        r            = '0;
        r.kind       = KIND_READING;
        r.ref_select = REF_NONE;
        r.range_used = drive_ref - 2'd1;
        if (is_open) begin
            r.ohms_x16     = '1;
            r.open_circuit = 1'b1;
        end else begin
            scaled         = (num << FRAC_BITS) / den;
            r.ohms_x16     = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
            r.continuity   = num < 64'(cont_limit) * den;
            r.open_circuit = num > 64'(OVER_LIMIT) * den;
        end
        start_pass(REF_NONE, PHASE_IDLE);
        expected_readings.push_back(r);
    endfunction

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endfunction

    function automatic void check_reading(input t_out_item got);
        t_out_item want;
        if (expected_readings.size() == 0) begin
            $error("unexpected reading: kind %0d ref_select %0d ohms_x16 %0d",
                   got.kind, got.ref_select, got.ohms_x16);
            o_errors++;
            return;
        end
        want = expected_readings.pop_front();
        compare_field("kind", want.kind, got.kind);
        compare_field("ref_select", want.ref_select, got.ref_select);
        compare_field("ohms_x16", want.ohms_x16, got.ohms_x16);
        compare_field("range_used", want.range_used, got.range_used);
        compare_field("continuity", want.continuity, got.continuity);
        compare_field("open_circuit", want.open_circuit, got.open_circuit);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            full_mv    = RST_ADC_FULL;
            ref_low_r  = RST_REF_LOW;
            ref_mid_r  = RST_REF_MID;
            ref_high_r = RST_REF_HIGH;
            cont_limit = RST_CONT_LIMIT;
            start_pass(REF_NONE, PHASE_IDLE);
            expected_readings.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                write_reg(i_cfg_data);
            if (i_res_valid && i_res_ready)
                check_reading(i_res_data);
            if (i_samp_valid && i_samp_ready)
                predict_reading(i_samp_data);
        end
        o_pending = expected_readings.size();
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Top of the ohmmeter testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb;
    import aom_pkg::*;

    localparam int   SAMPLES     = 16;
    localparam int   FRAC_BITS   = 4;
    localparam int   DIV_WAIT    = 64;
    localparam int   HOLD_CYCLES = 500;
    localparam int   CYCLE_LIMIT = 400000;
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_START  = 1'b1;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    int          error_count;
    int          pending_count;
    int unsigned cycle_count = 0;
    int unsigned sent_items  = 0;
    bit          idling_on   = 1'b1;
    bit          hold_req    = 1'b0;

    aom_chan_if #(.T(t_in_item))  samp_ch ();
    aom_chan_if #(.T(t_out_item)) res_ch ();
    aom_chan_if #(.T(t_cfg_item)) cfg_ch ();

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    autorange_ohmmeter #(
        .SAMPLES_PER_READING(SAMPLES),
        .OHMS_FRACTION_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_samp (samp_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    aom_reading_check #(
        .SAMPLES  (SAMPLES),
        .FRAC_BITS(FRAC_BITS)
    ) u_reading_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_samp_valid(samp_ch.valid),
        .i_samp_ready(samp_ch.ready),
        .i_samp_data (samp_ch.data),
        .i_res_valid (res_ch.valid),
        .i_res_ready (res_ch.ready),
        .i_res_data  (res_ch.data),
        .i_cfg_valid (cfg_ch.valid),
        .i_cfg_ready (cfg_ch.ready),
        .i_cfg_data  (cfg_ch.data),
        .o_errors    (error_count),
        .o_pending   (pending_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : rx_side
        int unsigned span;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                span = $urandom_range(1, 15);
                repeat (span - 1) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                span = $urandom_range(1, 15);
                repeat (span - 1) @(negedge i_clk);
            end
        end
    end

    task automatic pause_input(input int unsigned span);
        @(negedge i_clk);
        samp_ch.valid <= 1'b0;
        repeat (span - 1) @(negedge i_clk);
    endtask

    task automatic send_item(input logic mode, input logic [11:0] mv);
        t_in_item it;
        it.mode      = mode;
        it.sample_mv = mv;
        if (idling_on && $urandom_range(0, 7) == 0)
            pause_input($urandom_range(1, 15));
        @(negedge i_clk);
        samp_ch.valid <= 1'b1;
        samp_ch.data  <= it;
        @(posedge i_clk);
        while (!samp_ch.ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_pass();
        logic [11:0] base;
        int          jit;
        int          v;
        case ($urandom_range(0, 9))
            0:       base = 12'($urandom_range(0, 60));
            1: begin
                case ($urandom_range(0, 3))
                    0:       base = 12'd50;
                    1:       base = 12'd51;
                    2:       base = 12'd3199;
                    default: base = 12'd3200;
                endcase
            end
            2, 3:    base = 12'($urandom_range(3000, 4095));
            4, 5, 6: base = 12'($urandom_range(0, 1200));
            default: base = 12'($urandom_range(0, 4095));
        endcase
        case ($urandom_range(0, 5))
            0, 1:    jit = 0;
            2:       jit = 4095;
            default: jit = $urandom_range(1, 40);
        endcase
        repeat (SAMPLES) begin
            v = int'(base) + int'($urandom_range(0, 2 * jit)) - jit;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            send_item(MODE_SAMPLE, 12'(v));
        end
    endtask

    // second pass completes a ranged reading, or falls on an idle block
    task automatic measurement();
        send_item(MODE_START, 12'($urandom_range(0, 4095)));
        send_pass();
        send_pass();
    endtask

    task automatic drain();
        @(negedge i_clk);
        samp_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DIV_WAIT) @(negedge i_clk);
    endtask

    task automatic finish_phase();
        measurement();
        drain();
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [15:0] value);
        t_cfg_item w;
        w.addr  = addr;
        w.wdata = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [15:0] adc_mv, input logic [15:0] lo,
                                 input logic [15:0] mid, input logic [15:0] hi,
                                 input logic [15:0] limit);
        cfg_write(CFG_ADC_FULL, adc_mv);
        cfg_write(CFG_REF_LOW, lo);
        cfg_write(CFG_REF_MID, mid);
        cfg_write(CFG_REF_HIGH, hi);
        cfg_write(CFG_CONT_LIMIT, limit);
    endtask

    task automatic apply_random_setting();
        apply_setting(16'($urandom_range(1500, 4095)), 16'($urandom_range(1, 65535)),
                      16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                      16'($urandom_range(0, 2000)));
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned target;
        target = sent_items + count;
        while (sent_items < target) begin
            case ($urandom_range(0, 9))
                7: begin
                    send_item(MODE_START, 12'($urandom_range(0, 4095)));
                    repeat ($urandom_range(1, 20))
                        send_item(MODE_SAMPLE, 12'($urandom_range(0, 4095)));
                end
                8: begin
                    repeat ($urandom_range(1, 5))
                        send_item(MODE_SAMPLE, 12'($urandom_range(0, 4095)));
                end
                9: begin
                    repeat ($urandom_range(1, 8))
                        send_item(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                end
                default: measurement();
            endcase
        end
    endtask

    initial begin
        samp_ch.valid = 1'b0;
        samp_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // samples while idle, start with sample bits set, abandon, then open
        send_item(MODE_SAMPLE, 12'd4095);
        send_item(MODE_SAMPLE, 12'd0);
        send_item(MODE_START, 12'hFFF);
        repeat (3) send_item(MODE_SAMPLE, 12'd0);
        send_item(MODE_START, 12'd0);
        repeat (SAMPLES) send_item(MODE_SAMPLE, 12'd4095);
        finish_phase();

        apply_setting(16'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(150);
        finish_phase();

        apply_setting(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
        random_phase(150);
        finish_phase();

        // supply with high bits set, zero references
        apply_setting(16'hF6A4, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        random_phase(150);
        finish_phase();

        repeat (2) begin
            apply_random_setting();
            random_phase(150);
            finish_phase();
        end

        apply_random_setting();
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_item((i % 3 == 0) ? MODE_START : MODE_SAMPLE, 12'($urandom_range(0, 4095)));
        random_phase(120);
        finish_phase();

        idling_on = 1'b0;
        apply_setting(16'(RST_ADC_FULL), RST_REF_LOW, RST_REF_MID, RST_REF_HIGH,
                      RST_CONT_LIMIT);
        random_phase(150);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
